>>> rtl/core/anx_pkg.sv
package anx_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int COUNT_BITS  = 24;
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_BITS   = $clog2(MAX_RESULTS);
    localparam int NUM_BITS    = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_START = 8'h01;
    localparam logic [7:0] BYTE_EPB   = 8'h03;
    localparam logic [4:0] TYPE_IDR   = 5'd5;

    // held zero run: three means two held and at least one dropped
    localparam logic [1:0] ZEROS_NONE   = 2'd0;
    localparam logic [1:0] ZEROS_ONE    = 2'd1;
    localparam logic [1:0] ZEROS_TWO    = 2'd2;
    localparam logic [1:0] ZEROS_EXCESS = 2'd3;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_END     = 2'd2
    } anx_kind_t;

    typedef struct packed {
        anx_kind_t              kind;
        logic [7:0]             data;
        logic [LENGTH_BITS-1:0] len;
        logic [COUNT_BITS-1:0]  units;
        logic [COUNT_BITS-1:0]  idr;
    } anx_slot_t;

    typedef struct packed {
        anx_slot_t [MAX_RESULTS-1:0] slot;
        logic [NUM_BITS-1:0]         count;
        logic                        err;
        logic                        load;
    } anx_bundle_t;

    function automatic logic [LENGTH_BITS-1:0] sat_len_inc(input logic [LENGTH_BITS-1:0] v);
        return (&v) ? v : v + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_cnt_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    endfunction

endpackage

>>> rtl/core/anx_in_if.sv
interface anx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       end_of_stream;

    modport source (output valid, output stream_byte, output end_of_stream, input ready);
    modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

>>> rtl/core/anx_out_if.sv
interface anx_out_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         item_kind;
    logic [7:0]                         data_byte;
    logic                               forbidden_bit;
    logic [1:0]                         ref_idc;
    logic [4:0]                         unit_type;
    logic [anx_pkg::LENGTH_BITS-1:0]    payload_length;
    logic [anx_pkg::COUNT_BITS-1:0]     units_seen;
    logic [anx_pkg::COUNT_BITS-1:0]     idr_units_seen;
    logic                               stream_error;
    logic                               last;

    modport source (
        output valid, output item_kind, output data_byte, output forbidden_bit,
        output ref_idc, output unit_type, output payload_length, output units_seen,
        output idr_units_seen, output stream_error, output last, input ready
    );
    modport sink (
        input valid, input item_kind, input data_byte, input forbidden_bit,
        input ref_idc, input unit_type, input payload_length, input units_seen,
        input idr_units_seen, input stream_error, input last, output ready
    );
endinterface

>>> rtl/core/anx_parse.sv
module anx_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    anx_in_if.sink               stream,
    input  logic                 free,
    output anx_pkg::anx_bundle_t bundle
);

    logic                            in_valid_reg;
    logic [7:0]                      byte_reg;
    logic                            eos_reg;

    logic [1:0]                      held_reg, held_next;
    logic                            inside_reg, inside_next;
    logic                            await_reg, await_next;
    logic [anx_pkg::LENGTH_BITS-1:0] pc_reg, pc_next;
    logic [anx_pkg::COUNT_BITS-1:0]  uc_reg, uc_next;
    logic [anx_pkg::COUNT_BITS-1:0]  idr_reg, idr_next;

    logic [anx_pkg::NUM_BITS-1:0]    n;
    logic                            err;
    logic                            removed;
    anx_pkg::anx_slot_t [anx_pkg::MAX_RESULTS-1:0] slots;
    logic                            advance;

    always_comb
    begin
        held_next   = held_reg;
        inside_next = inside_reg;
        await_next  = await_reg;
        pc_next     = pc_reg;
        uc_next     = uc_reg;
        idr_next    = idr_reg;
        n           = '0;
        err         = 1'b0;
        removed     = 1'b0;
        slots       = '0;

        if (await_reg)
        begin
            if (byte_reg[4:0] == anx_pkg::TYPE_IDR)
            begin
                idr_next = anx_pkg::sat_cnt_inc(idr_next);
            end
            slots[n[anx_pkg::SLOT_BITS-1:0]] =
                '{anx_pkg::KIND_HEADER, byte_reg, '0, uc_next, idr_next};
            n          = n + anx_pkg::NUM_BITS'(1);
            await_next = 1'b0;
            held_next  = anx_pkg::ZEROS_NONE;
        end
        else if (byte_reg == anx_pkg::BYTE_ZERO)
        begin
            if (held_next != anx_pkg::ZEROS_EXCESS)
            begin
                held_next = held_next + 2'd1;
            end
        end
        else
        begin
            if (held_next == anx_pkg::ZEROS_EXCESS && byte_reg != anx_pkg::BYTE_START)
            begin
                err = 1'b1;
            end
            if (held_next >= anx_pkg::ZEROS_TWO && byte_reg == anx_pkg::BYTE_START)
            begin
                // start code: close the open unit first
                if (inside_next)
                begin
                    slots[n[anx_pkg::SLOT_BITS-1:0]] =
                        '{anx_pkg::KIND_END, 8'h00, pc_next, uc_next, idr_next};
                    n = n + anx_pkg::NUM_BITS'(1);
                end
                uc_next     = anx_pkg::sat_cnt_inc(uc_next);
                inside_next = 1'b1;
                await_next  = 1'b1;
                pc_next     = '0;
            end
            else if (inside_next)
            begin
                removed = (held_next >= anx_pkg::ZEROS_TWO) && (byte_reg == anx_pkg::BYTE_EPB);
                if (held_next >= anx_pkg::ZEROS_ONE)
                begin
                    slots[n[anx_pkg::SLOT_BITS-1:0]] =
                        '{anx_pkg::KIND_PAYLOAD, 8'h00, '0, uc_next, idr_next};
                    n       = n + anx_pkg::NUM_BITS'(1);
                    pc_next = anx_pkg::sat_len_inc(pc_next);
                end
                if (held_next >= anx_pkg::ZEROS_TWO)
                begin
                    slots[n[anx_pkg::SLOT_BITS-1:0]] =
                        '{anx_pkg::KIND_PAYLOAD, 8'h00, '0, uc_next, idr_next};
                    n       = n + anx_pkg::NUM_BITS'(1);
                    pc_next = anx_pkg::sat_len_inc(pc_next);
                end
                if (!removed)
                begin
                    slots[n[anx_pkg::SLOT_BITS-1:0]] =
                        '{anx_pkg::KIND_PAYLOAD, byte_reg, '0, uc_next, idr_next};
                    n       = n + anx_pkg::NUM_BITS'(1);
                    pc_next = anx_pkg::sat_len_inc(pc_next);
                end
            end
            held_next = anx_pkg::ZEROS_NONE;
        end

        if (eos_reg)
        begin
            if (held_next == anx_pkg::ZEROS_EXCESS)
            begin
                err = 1'b1;
            end
            if (inside_next)
            begin
                // flush held zeros, then close the unit
                if (!await_next && held_next >= anx_pkg::ZEROS_ONE)
                begin
                    slots[n[anx_pkg::SLOT_BITS-1:0]] =
                        '{anx_pkg::KIND_PAYLOAD, 8'h00, '0, uc_next, idr_next};
                    n       = n + anx_pkg::NUM_BITS'(1);
                    pc_next = anx_pkg::sat_len_inc(pc_next);
                end
                if (!await_next && held_next >= anx_pkg::ZEROS_TWO)
                begin
                    slots[n[anx_pkg::SLOT_BITS-1:0]] =
                        '{anx_pkg::KIND_PAYLOAD, 8'h00, '0, uc_next, idr_next};
                    n       = n + anx_pkg::NUM_BITS'(1);
                    pc_next = anx_pkg::sat_len_inc(pc_next);
                end
                slots[n[anx_pkg::SLOT_BITS-1:0]] =
                    '{anx_pkg::KIND_END, 8'h00, pc_next, uc_next, idr_next};
                n = n + anx_pkg::NUM_BITS'(1);
            end
            inside_next = 1'b0;
            await_next  = 1'b0;
            held_next   = anx_pkg::ZEROS_NONE;
            pc_next     = '0;
        end
    end

    // items with no result never wait for the result buffer
    assign advance      = in_valid_reg && ((n == '0) || free);
    assign stream.ready = !in_valid_reg || advance;

    assign bundle.slot  = slots;
    assign bundle.count = n;
    assign bundle.err   = err;
    assign bundle.load  = advance && (n != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            held_reg     <= anx_pkg::ZEROS_NONE;
            inside_reg   <= 1'b0;
            await_reg    <= 1'b0;
            pc_reg       <= '0;
            uc_reg       <= '0;
            idr_reg      <= '0;
        end
        else
        begin
            if (stream.valid && stream.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                held_reg   <= held_next;
                inside_reg <= inside_next;
                await_reg  <= await_next;
                pc_reg     <= pc_next;
                uc_reg     <= uc_next;
                idr_reg    <= idr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            byte_reg <= stream.stream_byte;
            eos_reg  <= stream.end_of_stream;
        end
    end

`ifndef SYNTH
    a_await_inside: assert property (@(posedge clk) disable iff (!rst_n)
        await_reg |-> inside_reg)
        else $error("header pending outside a unit");
    a_await_no_zeros: assert property (@(posedge clk) disable iff (!rst_n)
        await_reg |-> (held_reg == anx_pkg::ZEROS_NONE))
        else $error("zeros held while header pending");
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        bundle.load |-> (bundle.count != '0 &&
                         bundle.count <= anx_pkg::NUM_BITS'(anx_pkg::MAX_RESULTS)))
        else $error("bad result count on load");
`endif

endmodule

>>> rtl/core/anx_emit.sv
module anx_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  anx_pkg::anx_bundle_t bundle,
    output logic                 free,
    anx_out_if.source            result
);

    anx_pkg::anx_slot_t [anx_pkg::MAX_RESULTS-1:0] slots_reg;
    logic                               err_reg;
    logic [anx_pkg::NUM_BITS-1:0]       remain_reg;
    logic [anx_pkg::SLOT_BITS-1:0]      idx_reg;
    anx_pkg::anx_slot_t                 cur;
    logic                               hdr;
    logic                               take;

    assign cur  = slots_reg[idx_reg];
    assign hdr  = (cur.kind == anx_pkg::KIND_HEADER);
    assign take = result.valid && result.ready;
    // buffer can load when empty or when its final item leaves this cycle
    assign free = (remain_reg == '0) ||
                  ((remain_reg == anx_pkg::NUM_BITS'(1)) && result.ready);

    assign result.valid          = (remain_reg != '0);
    assign result.item_kind      = cur.kind;
    assign result.data_byte      = cur.data;
    assign result.forbidden_bit  = hdr & cur.data[7];
    assign result.ref_idc        = hdr ? cur.data[6:5] : 2'd0;
    assign result.unit_type      = hdr ? cur.data[4:0] : 5'd0;
    assign result.payload_length = cur.len;
    assign result.units_seen     = cur.units;
    assign result.idr_units_seen = cur.idr;
    assign result.stream_error   = err_reg;
    assign result.last           = (remain_reg == anx_pkg::NUM_BITS'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            idx_reg    <= '0;
        end
        else if (bundle.load)
        begin
            remain_reg <= bundle.count;
            idx_reg    <= '0;
        end
        else if (take)
        begin
            remain_reg <= remain_reg - anx_pkg::NUM_BITS'(1);
            idx_reg    <= idx_reg + anx_pkg::SLOT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (bundle.load)
        begin
            slots_reg <= bundle.slot;
            err_reg   <= bundle.err;
        end
    end

`ifndef SYNTH
    a_load_remain: assert property (@(posedge clk) disable iff (!rst_n)
        bundle.load |=> (remain_reg == $past(bundle.count)))
        else $error("result count not captured");
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        bundle.load |-> free)
        else $error("load over pending results");
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> (result.valid && $stable(idx_reg)))
        else $error("pending result not held");
`endif

endmodule

>>> rtl/core/annexb_nal_unit_extractor.sv
// Annex B NAL unit extractor: start code search, header decode, 03 removal.
// A byte waits in the input register until the result buffer is free, and
// its results are then loaded into the buffer. Throughput: one byte per cycle
// while the buffer is free; a byte with k results (0..4) holds the buffer
// until all k have left, one result per cycle while the receiver is ready.
// Reset (rst_n low, asynchronous) clears parse state, counters and buffers.
module annexb_nal_unit_extractor (
    input  logic      clk,
    input  logic      rst_n,
    anx_in_if.sink    stream,
    anx_out_if.source result
);

    // Parse stage: input register plus parse state. All results of one byte
    // are built at once from the registered byte and state, then handed over
    // as a bundle together with the counter values each result must show.
    anx_pkg::anx_bundle_t bundle;
    logic                 free;

    anx_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .free   (free),
        .bundle (bundle)
    );

    // Emit stage: hold the bundle and step out one result item per cycle while
    // ready is high, marking the final one. A byte with no result bypasses it.
    anx_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .bundle (bundle),
        .free   (free),
        .result (result)
    );

endmodule

>>> bench/annexb_nal_unit_extractor_test.sv
module annexb_nal_unit_extractor_test;

    timeunit 1ns;
    timeprecision 1ps;

    import anx_pkg::*;

    // Give up on a hung run well after the slowest legal one. About 430
    // bytes, each waiting out a long sender gap and up to four results,
    // and each result waiting out a long receiver stall.
    localparam int CYCLE_LIMIT   = 400_000;
    // Let the pipe settle at the end, after the last result has come out.
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ITEMS  = 400;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AFTER    = 120;
    localparam int REPORT_LIMIT  = 10;
    localparam int NOT_TYPED     = -1;

    // One result item as the output channel carries it.
    typedef struct packed {
        anx_kind_t              kind;
        logic [7:0]             data;
        logic                   fbit;
        logic [1:0]             nri;
        logic [4:0]             utype;
        logic [LENGTH_BITS-1:0] len;
        logic [COUNT_BITS-1:0]  units;
        logic [COUNT_BITS-1:0]  idr;
        logic                   err;
        logic                   last;
    } nal_item_t;

    // One input item of the stream.
    typedef struct packed {
        logic [7:0] value;
        logic       eos;
    } stream_item_t;

    // Directed row: the byte to send and, where it is obvious, the result
    // count and the first result's kind, byte and error flag.
    typedef struct packed {
        logic [7:0] value;
        logic       eos;
        int         count;
        anx_kind_t  kind;
        logic [7:0] data;
        logic       err;
    } directed_row_t;

    logic clk;
    logic rst_n;

    anx_in_if  stream_ch ();
    anx_out_if result_ch ();

    annexb_nal_unit_extractor i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .result (result_ch)
    );

    // Shadow parser state.
    logic [1:0]             zero_run;
    logic                   in_unit;
    logic                   want_header;
    logic [LENGTH_BITS-1:0] rbsp_count;
    logic [COUNT_BITS-1:0]  unit_total;
    logic [COUNT_BITS-1:0]  idr_total;
    logic                   byte_err;

    nal_item_t    byte_results [$];
    nal_item_t    expected_nal_items [$];
    stream_item_t random_stream [$];

    int  failures;
    int  results_checked;
    int  cycle_count;
    bit  sender_burst;

    // Walk the stream through start codes, header, emulation prevention,
    // excess zeros and end of stream.
    directed_row_t directed_rows [0:26] = '{
        '{8'hAA, 1'b0, 0,         KIND_HEADER,  8'h00, 1'b0},  // junk before any start
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},
        '{8'h01, 1'b0, 0,         KIND_HEADER,  8'h00, 1'b0},  // first start code
        '{8'hE5, 1'b0, 1,         KIND_HEADER,  8'hE5, 1'b0},  // IDR, all flags set
        '{8'hFF, 1'b0, 1,         KIND_PAYLOAD, 8'hFF, 1'b0},
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},
        '{8'h03, 1'b0, 2,         KIND_PAYLOAD, 8'h00, 1'b0},  // 03 removed
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},  // third zero dropped
        '{8'h42, 1'b0, 3,         KIND_PAYLOAD, 8'h00, 1'b1},  // excess zeros flagged
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},
        '{8'h01, 1'b0, 1,         KIND_END,     8'h00, 1'b0},  // start closes unit
        '{8'h00, 1'b0, 1,         KIND_HEADER,  8'h00, 1'b0},  // header of zero
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},
        '{8'h02, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},  // 00 00 02 passes
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},
        '{8'h01, 1'b0, 1,         KIND_END,     8'h00, 1'b0},
        '{8'h01, 1'b0, 1,         KIND_HEADER,  8'h01, 1'b0},  // header of 01
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},
        '{8'h00, 1'b0, NOT_TYPED, KIND_HEADER,  8'h00, 1'b0},
        '{8'h00, 1'b1, 3,         KIND_PAYLOAD, 8'h00, 1'b1}   // end with excess zeros
    };

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic string describe(input nal_item_t r);
        return $sformatf({"kind %0d data %02h fbit %0b nri %0d type %0d len %0d",
                          " units %0d idr %0d err %0b last %0b"},
                         r.kind, r.data, r.fbit, r.nri, r.utype, r.len,
                         r.units, r.idr, r.err, r.last);
    endfunction

    function automatic void note_failure(input string what);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Append one result for the current byte, counters as they stand now.
    function automatic void emit(input anx_kind_t kind, input logic [7:0] value);
        nal_item_t r;
        r.kind  = kind;
        r.data  = (kind == KIND_END) ? 8'h00 : value;
        r.fbit  = (kind == KIND_HEADER) ? value[7] : 1'b0;
        r.nri   = (kind == KIND_HEADER) ? value[6:5] : 2'd0;
        r.utype = (kind == KIND_HEADER) ? value[4:0] : 5'd0;
        r.len   = (kind == KIND_END) ? rbsp_count : '0;
        r.units = unit_total;
        r.idr   = idr_total;
        r.err   = byte_err;
        r.last  = 1'b0;
        byte_results.push_back(r);
    endfunction

    function automatic void emit_payload(input logic [7:0] value);
        emit(KIND_PAYLOAD, value);
        if (!(&rbsp_count))
            rbsp_count = rbsp_count + LENGTH_BITS'(1);
    endfunction

    // Release held zeros as payload; never more than two survive.
    function automatic void release_zeros();
        int held;
        held = (zero_run == ZEROS_EXCESS) ? 2 : int'(zero_run);
        repeat (held) emit_payload(BYTE_ZERO);
    endfunction

    // Advance the shadow parser by one accepted byte and queue its results.
    function automatic void parse_byte(input logic [7:0] value, input logic eos);
        logic epb;
        byte_results.delete();
        byte_err = 1'b0;
        if (want_header)
        begin
            // The byte right after a start code is always the header.
            if (value[4:0] == TYPE_IDR && !(&idr_total))
                idr_total = idr_total + COUNT_BITS'(1);
            emit(KIND_HEADER, value);
            want_header = 1'b0;
            zero_run    = ZEROS_NONE;
        end
        else if (value == BYTE_ZERO)
        begin
            if (zero_run != ZEROS_EXCESS)
                zero_run = zero_run + 2'd1;
        end
        else
        begin
            if (zero_run == ZEROS_EXCESS && value != BYTE_START)
                byte_err = 1'b1;
            if (zero_run >= ZEROS_TWO && value == BYTE_START)
            begin
                if (in_unit)
                    emit(KIND_END, BYTE_ZERO);
                if (!(&unit_total))
                    unit_total = unit_total + COUNT_BITS'(1);
                in_unit     = 1'b1;
                want_header = 1'b1;
                rbsp_count  = '0;
            end
            else if (in_unit)
            begin
                epb = (zero_run >= ZEROS_TWO) && (value == BYTE_EPB);
                release_zeros();
                if (!epb)
                    emit_payload(value);
            end
            zero_run = ZEROS_NONE;
        end
        if (eos)
        begin
            if (zero_run == ZEROS_EXCESS)
                byte_err = 1'b1;
            if (in_unit)
            begin
                if (!want_header)
                    release_zeros();
                emit(KIND_END, BYTE_ZERO);
            end
            in_unit     = 1'b0;
            want_header = 1'b0;
            zero_run    = ZEROS_NONE;
            rbsp_count  = '0;
        end
        if (byte_results.size() > 0)
            byte_results[$].last = 1'b1;
        foreach (byte_results[i])
            expected_nal_items.push_back(byte_results[i]);
    endfunction

    // Offer one item after a random gap, hold it until accepted, then
    // predict its results. Valid stays high between back-to-back items.
    task automatic offer(input logic [7:0] value, input logic eos);
        int gap;
        if ($urandom_range(0, 31) == 0)
            sender_burst = !sender_burst;
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            stream_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_ch.valid         <= 1'b1;
        stream_ch.stream_byte   <= value;
        stream_ch.end_of_stream <= eos;
        @(posedge clk);
        while (!stream_ch.ready) @(posedge clk);
        parse_byte(value, eos);
    endtask

    // Payload bytes lean hard on 00, 03 and 01 to hit the corner patterns.
    function automatic logic [7:0] payload_byte();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return BYTE_ZERO;
        if (roll == 4)
            return BYTE_EPB;
        if (roll == 5)
            return BYTE_START;
        if (roll == 6)
            return 8'h02;
        return 8'($urandom_range(0, 255));
    endfunction

    // Plan one chunk of the random stream: mostly a well-formed unit with
    // random content, sometimes plain noise.
    function automatic void plan_chunk();
        int           zeros;
        int           body;
        stream_item_t it;
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 6))
            begin
                it.value = 8'($urandom_range(0, 255));
                it.eos   = ($urandom_range(0, 9) == 0);
                random_stream.push_back(it);
            end
            return;
        end
        zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : 2;
        it.eos = 1'b0;
        repeat (zeros)
        begin
            it.value = BYTE_ZERO;
            random_stream.push_back(it);
        end
        it.value = BYTE_START;
        random_stream.push_back(it);
        // Now and then cut the stream while the header is still due.
        if ($urandom_range(0, 19) == 0)
        begin
            random_stream[$].eos = 1'b1;
            return;
        end
        it.value = ($urandom_range(0, 3) == 0) ? {3'($urandom_range(0, 7)), TYPE_IDR}
                                               : 8'($urandom_range(0, 255));
        random_stream.push_back(it);
        body = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 10);
        repeat (body)
        begin
            it.value = payload_byte();
            random_stream.push_back(it);
        end
        if ($urandom_range(0, 7) == 0)
            random_stream[$].eos = 1'b1;
    endfunction

    // Stop the run if it hangs.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: check each accepted result against the oldest expectation
    // and drive ready with random stalls, calm stretches and one long hold.
    initial
    begin
        nal_item_t got;
        nal_item_t want;
        int        stall_left;
        int        hold_left;
        bit        hold_done;
        bit        calm;
        stall_left      = 0;
        hold_left       = 0;
        hold_done       = 1'b0;
        calm            = 1'b0;
        results_checked = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                got.kind  = anx_kind_t'(result_ch.item_kind);
                got.data  = result_ch.data_byte;
                got.fbit  = result_ch.forbidden_bit;
                got.nri   = result_ch.ref_idc;
                got.utype = result_ch.unit_type;
                got.len   = result_ch.payload_length;
                got.units = result_ch.units_seen;
                got.idr   = result_ch.idr_units_seen;
                got.err   = result_ch.stream_error;
                got.last  = result_ch.last;
                if (expected_nal_items.size() == 0)
                    note_failure({"result with nothing expected: ", describe(got)});
                else
                begin
                    want = expected_nal_items.pop_front();
                    if (got !== want)
                        note_failure({"expected ", describe(want), " got ", describe(got)});
                end
                results_checked++;
            end
            if ($urandom_range(0, 63) == 0)
                calm = !calm;
            // Hold off long once, so the block backs up into its input.
            if (!hold_done && results_checked >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= (rst_n === 1'b1);
        end
    end

    // Sender: reset, directed rows, random stream, drain, verdict.
    initial
    begin
        int half;
        failures     = 0;
        sender_burst = 1'b0;
        zero_run     = ZEROS_NONE;
        in_unit      = 1'b0;
        want_header  = 1'b0;
        rbsp_count   = '0;
        unit_total   = '0;
        idr_total    = '0;
        byte_err     = 1'b0;
        rst_n                   <= 1'b0;
        stream_ch.valid         <= 1'b0;
        stream_ch.stream_byte   <= 8'h00;
        stream_ch.end_of_stream <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; cross-check the obvious ones against the predictor.
        foreach (directed_rows[i])
        begin
            offer(directed_rows[i].value, directed_rows[i].eos);
            if (directed_rows[i].count != NOT_TYPED)
            begin
                if (byte_results.size() != directed_rows[i].count)
                    note_failure($sformatf("row %0d: %0d results predicted, %0d listed",
                                           i, byte_results.size(),
                                           directed_rows[i].count));
                else if (directed_rows[i].count > 0 &&
                         (byte_results[0].kind !== directed_rows[i].kind ||
                          byte_results[0].data !== directed_rows[i].data ||
                          byte_results[0].err  !== directed_rows[i].err))
                    note_failure($sformatf("row %0d: listed kind %0d data %02h err %0b, %s",
                                           i, directed_rows[i].kind, directed_rows[i].data,
                                           directed_rows[i].err,
                                           describe(byte_results[0])));
            end
        end

        while (random_stream.size() < RANDOM_ITEMS)
            plan_chunk();
        half = random_stream.size() / 2;
        foreach (random_stream[i])
        begin
            // Pause once midway until every predicted result has come out.
            if (i == half)
            begin
                stream_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_nal_items.size() != 0);
            end
            offer(random_stream[i].value, random_stream[i].eos);
        end

        // Drop valid, wait for the last results, then let the pipe settle.
        stream_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_nal_items.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/anx_pkg.sv
rtl/core/anx_in_if.sv
rtl/core/anx_out_if.sv
rtl/core/anx_parse.sv
rtl/core/anx_emit.sv
rtl/core/annexb_nal_unit_extractor.sv
bench/annexb_nal_unit_extractor_test.sv
